[rtl/dsfa_pkg.sv]
// Package for the dining seat fork arbiter.
// Holds the seat state codes used by the back and the operation codes shared by the front, back and top level.
// No dependencies.
`default_nettype none

package dsfa_pkg;

  typedef enum logic [1:0] {
    SEAT_THINKING = 2'd0,
    SEAT_HUNGRY   = 2'd1,
    SEAT_EATING   = 2'd2
  } seat_e;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  localparam int unsigned CfgW = 5;
  localparam int unsigned SeatPortW = 4;
  localparam logic [CfgW-1:0] ACTIVE_SEATS_RESET = 5'd5;
  localparam int unsigned MIN_RING = 2;

endpackage

`default_nettype wire

[rtl/dsfa_fifo.sv]
// Small first-in first-out queue used between the front and back and at the output.
// Generic width and depth; no package dependency.
`default_nettype none

module dsfa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic                  full_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/dsfa_front.sv]
// Front end of the arbiter: holds the ring size register, drops events outside
// the ring and resolves neighbor indices. Depends on dsfa_pkg.
`default_nettype none

module dsfa_front #(
  parameter int unsigned MAX_SEATS = 16,
  localparam int unsigned IW = $clog2(MAX_SEATS)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            operation_i,
  input  wire logic [dsfa_pkg::SeatPortW-1:0]  seat_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [dsfa_pkg::CfgW-1:0]       cfg_wdata_i,
  input  wire logic                            q_full_i,
  output logic                                 in_stall_o,
  output logic                                 push_o,
  output logic [IW-1:0]                        s_o,
  output logic [IW-1:0]                        l_o,
  output logic [IW-1:0]                        r_o,
  output logic [IW-1:0]                        ll_o,
  output logic [IW-1:0]                        rr_o,
  output dsfa_pkg::op_e                        op_o
);

  localparam int unsigned NW = $clog2(MAX_SEATS + 1);

  logic [dsfa_pkg::CfgW-1:0] active_seats_q;
  logic [NW-1:0]             ring_n;
  logic                      in_ring;

  function automatic logic [IW-1:0] left_of(logic [IW-1:0] x, logic [NW-1:0] n);
    logic [IW-1:0] res;
    if (x == '0) begin
      res = IW'(n - NW'(1));
    end else begin
      res = x - IW'(1);
    end
    return res;
  endfunction

  function automatic logic [IW-1:0] right_of(logic [IW-1:0] x, logic [NW-1:0] n);
    logic [IW-1:0] res;
    if ((NW'(x) + NW'(1)) == n) begin
      res = '0;
    end else begin
      res = x + IW'(1);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_seats_q <= dsfa_pkg::ACTIVE_SEATS_RESET;
    end else if (cfg_we_i) begin
      active_seats_q <= cfg_wdata_i;
    end
  end

  // effective ring size, register saturated into [2, MAX_SEATS]
  always_comb begin
    if (32'(active_seats_q) > 32'(MAX_SEATS)) begin
      ring_n = NW'(MAX_SEATS);
    end else if (32'(active_seats_q) < 32'(dsfa_pkg::MIN_RING)) begin
      ring_n = NW'(dsfa_pkg::MIN_RING);
    end else begin
      ring_n = NW'(active_seats_q);
    end
  end

  assign in_ring    = (32'(seat_i) < 32'(ring_n));
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && in_ring;
  assign op_o       = dsfa_pkg::op_e'(operation_i);
  assign s_o        = IW'(seat_i);
  assign l_o        = left_of(s_o, ring_n);
  assign r_o        = right_of(s_o, ring_n);
  assign ll_o       = left_of(l_o, ring_n);
  assign rr_o       = right_of(r_o, ring_n);

endmodule

`default_nettype wire

[rtl/dsfa_back.sv]
// Back end of the arbiter: seat state memory and the sequencer that updates it
// and queues grants. Depends on dsfa_pkg and dsfa_fifo.
`default_nettype none

module dsfa_back #(
  parameter int unsigned MAX_SEATS = 16,
  localparam int unsigned IW = $clog2(MAX_SEATS)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  input  wire dsfa_pkg::op_e                   cmd_op_i,
  input  wire logic [IW-1:0]                   cmd_s_i,
  input  wire logic [IW-1:0]                   cmd_l_i,
  input  wire logic [IW-1:0]                   cmd_r_i,
  input  wire logic [IW-1:0]                   cmd_ll_i,
  input  wire logic [IW-1:0]                   cmd_rr_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [dsfa_pkg::SeatPortW-1:0]       grant_seat_o,
  output logic                                 last_grant_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ,
    ST_REL_L,
    ST_REL_R,
    ST_EMIT_R
  } state_e;

  typedef struct packed {
    dsfa_pkg::op_e op;
    logic [IW-1:0] s;
    logic [IW-1:0] l;
    logic [IW-1:0] r;
    logic [IW-1:0] rr;
  } cmd_t;

  typedef struct packed {
    logic [IW-1:0] seat;
    logic          last;
  } grant_t;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic   gl_q, gl_d;

  // seat state memory, valid bits stand in for the reset value
  logic [1:0]           mem_q [MAX_SEATS];
  logic [MAX_SEATS-1:0] valid_q;
  logic [1:0]           rd_a_q, rd_b_q;
  logic                 rd_va_q, rd_vb_q;
  logic                 rd_en, wr_en;
  logic [IW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
  dsfa_pkg::seat_e      wr_data;
  dsfa_pkg::seat_e      a_st, b_st, a_eff, b_eff;

  logic   grant, gl, gr;
  logic   push, out_full, out_pop;
  grant_t push_data, head;

  assign a_st = rd_va_q ? dsfa_pkg::seat_e'(rd_a_q) : dsfa_pkg::SEAT_THINKING;
  assign b_st = rd_vb_q ? dsfa_pkg::seat_e'(rd_b_q) : dsfa_pkg::SEAT_THINKING;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    gl_d      = gl_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr_a = cmd_l_i;
    rd_addr_b = cmd_r_i;
    wr_en     = 1'b0;
    wr_addr   = cmd_q.s;
    wr_data   = dsfa_pkg::SEAT_THINKING;
    push      = 1'b0;
    push_data = '{seat: cmd_q.s, last: 1'b1};
    a_eff     = a_st;
    b_eff     = b_st;
    grant     = 1'b0;
    gl        = 1'b0;
    gr        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = '{op: cmd_op_i, s: cmd_s_i, l: cmd_l_i, r: cmd_r_i, rr: cmd_rr_i};
          rd_en     = 1'b1;
          if (cmd_op_i == dsfa_pkg::OP_RELEASE) begin
            rd_addr_b = cmd_ll_i;
            wr_en     = 1'b1;
            wr_addr   = cmd_s_i;
            wr_data   = dsfa_pkg::SEAT_THINKING;
            state_d   = ST_REL_L;
          end else begin
            state_d = ST_REQ;
          end
        end
      end
      ST_REQ: begin
        grant   = (a_st != dsfa_pkg::SEAT_EATING) && (b_st != dsfa_pkg::SEAT_EATING);
        wr_en   = 1'b1;
        wr_data = grant ? dsfa_pkg::SEAT_EATING : dsfa_pkg::SEAT_HUNGRY;
        push    = grant && !out_full;
        if (!grant || !out_full) begin
          state_d = ST_IDLE;
        end
      end
      ST_REL_L: begin
        // in a two-seat ring the far neighbor is the releasing seat itself
        b_eff     = (cmd_q.l == cmd_q.r && cmd_q.rr == cmd_q.s) ? dsfa_pkg::SEAT_THINKING
                                                                 : b_st;
        gl        = (a_st == dsfa_pkg::SEAT_HUNGRY) && (b_eff != dsfa_pkg::SEAT_EATING);
        wr_en     = gl;
        wr_addr   = cmd_q.l;
        wr_data   = dsfa_pkg::SEAT_EATING;
        rd_en     = 1'b1;
        rd_addr_a = cmd_q.r;
        rd_addr_b = cmd_q.rr;
        gl_d      = gl;
        state_d   = ST_REL_R;
      end
      ST_REL_R: begin
        // reads were issued while the left grant was being written
        a_eff = (cmd_q.r == cmd_q.l && gl_q) ? dsfa_pkg::SEAT_EATING : a_st;
        if (cmd_q.rr == cmd_q.l && gl_q) begin
          b_eff = dsfa_pkg::SEAT_EATING;
        end else if (cmd_q.rr == cmd_q.s) begin
          b_eff = dsfa_pkg::SEAT_THINKING;
        end else begin
          b_eff = b_st;
        end
        gr      = (a_eff == dsfa_pkg::SEAT_HUNGRY) && (b_eff != dsfa_pkg::SEAT_EATING);
        wr_en   = gr;
        wr_addr = cmd_q.r;
        wr_data = dsfa_pkg::SEAT_EATING;
        if (gl_q) begin
          push      = !out_full;
          push_data = '{seat: cmd_q.l, last: !gr};
          if (!out_full) begin
            state_d = gr ? ST_EMIT_R : ST_IDLE;
          end
        end else begin
          push      = gr && !out_full;
          push_data = '{seat: cmd_q.r, last: 1'b1};
          if (!gr || !out_full) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT_R: begin
        push      = !out_full;
        push_data = '{seat: cmd_q.r, last: 1'b1};
        if (!out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gl_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      gl_q    <= gl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // read-before-write memory with registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q  <= mem_q[rd_addr_a];
      rd_b_q  <= mem_q[rd_addr_b];
      rd_va_q <= valid_q[rd_addr_a];
      rd_vb_q <= valid_q[rd_addr_b];
    end
  end

  assign out_pop = out_valid_o && !out_stall_i;

  dsfa_fifo #(
    .WIDTH($bits(grant_t)),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (out_pop),
    .valid_o    (out_valid_o),
    .full_o     (out_full),
    .data_o     (head)
  );

  assign grant_seat_o = dsfa_pkg::SeatPortW'(head.seat);
  assign last_grant_o = head.last;

endmodule

`default_nettype wire

[rtl/dining_seat_fork_arbiter.sv]
// Top level of the dining seat fork arbiter.
// Instantiates dsfa_front, dsfa_fifo and dsfa_back; uses dsfa_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event: operation_i
//   (0 request, 1 release) and seat_i. Events for seats outside the ring are
//   taken and dropped. Output channel (out_valid_o / out_stall_i) carries
//   grants: grant_seat_o and last_grant_o, the latter set on the final grant
//   of an event. The ring size register is written with cfg_we_i/cfg_wdata_i;
//   the user writes it only while the block is idle, which the block does not enforce.
//   Grants: a request grant is computed in ST_REQ from the registered seat state
//   read, release grants in ST_REL_R and ST_EMIT_R; all pass the output queue.
//   Events: the back-end sequencer over the single seat state memory
//   runs one event at a time: a request passes ST_IDLE and ST_REQ, a release
//   ST_IDLE, ST_REL_L and ST_REL_R, plus ST_EMIT_R when it grants both neighbors.
//   A two-entry event queue lets the input keep taking events meanwhile.
//   Reset: all seats thinking, ring size 5, both queues empty.
//   Output stall: grants wait in a two-entry output queue; when it is full the
//   sequencer holds on its next grant, then the event queue fills and in_stall_o rises.
`default_nettype none

module dining_seat_fork_arbiter #(
  parameter int unsigned MAX_SEATS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            operation_i,
  input  wire logic [dsfa_pkg::SeatPortW-1:0]  seat_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [dsfa_pkg::CfgW-1:0]       cfg_wdata_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [dsfa_pkg::SeatPortW-1:0]       grant_seat_o,
  output logic                                 last_grant_o
);

  localparam int unsigned IW = $clog2(MAX_SEATS);

  typedef struct packed {
    dsfa_pkg::op_e op;
    logic [IW-1:0] s;
    logic [IW-1:0] l;
    logic [IW-1:0] r;
    logic [IW-1:0] ll;
    logic [IW-1:0] rr;
  } cmd_t;

  cmd_t front_cmd, head_cmd;
  logic front_push, q_full, q_valid, q_pop;

  dsfa_front #(
    .MAX_SEATS(MAX_SEATS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .seat_i     (seat_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (front_push),
    .s_o        (front_cmd.s),
    .l_o        (front_cmd.l),
    .r_o        (front_cmd.r),
    .ll_o       (front_cmd.ll),
    .rr_o       (front_cmd.rr),
    .op_o       (front_cmd.op)
  );

  dsfa_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_push),
    .push_data_i(front_cmd),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .full_o     (q_full),
    .data_o     (head_cmd)
  );

  dsfa_back #(
    .MAX_SEATS(MAX_SEATS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_op_i    (head_cmd.op),
    .cmd_s_i     (head_cmd.s),
    .cmd_l_i     (head_cmd.l),
    .cmd_r_i     (head_cmd.r),
    .cmd_ll_i    (head_cmd.ll),
    .cmd_rr_i    (head_cmd.rr),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .grant_seat_o(grant_seat_o),
    .last_grant_o(last_grant_o)
  );

endmodule

`default_nettype wire

[rtl/dsfa_checker.sv]
// Port-level checks for the dining seat fork arbiter, bound to the top level.
// Depends on dsfa_pkg and dining_seat_fork_arbiter.
`default_nettype none

module dsfa_port_checks (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [dsfa_pkg::SeatPortW-1:0]  grant_seat_o,
  input wire logic                            last_grant_o
);

  // a stalled grant holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(grant_seat_o)
                                   && $stable(last_grant_o))
    else $error("stalled grant changed");

  // a non-final grant is followed at once by the second grant of the transaction
  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_grant_o |=> out_valid_o)
    else $error("second grant of a release not ready");

  // both grants of one release name different seats
  a_second_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_grant_o |=> grant_seat_o != $past(grant_seat_o))
    else $error("same seat granted twice by one release");

  // coming out of reset the event queue is not full and the output queue is empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_stall_o && !out_valid_o)
    else $error("queues not empty after reset");

endmodule

bind dining_seat_fork_arbiter dsfa_port_checks u_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .grant_seat_o(grant_seat_o),
  .last_grant_o(last_grant_o)
);

`default_nettype wire
